// File: rtl/gbts_pkg.sv
// gap buffer text store: shared types and constants
// used by the interfaces, controller, datapath and checker
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int REQ_W  = 2;
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE,
    S_SHIFT,
    S_RESP
  } state_t;

  // which address the store read port looks at
  typedef enum logic [1:0] {
    RD_NONE,
    RD_LEFT,
    RD_RIGHT,
    RD_POS
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    logic    shift_left;
    logic    shift_right;
    logic    ins_write;
    logic    del_pop;
    logic    load_result;
    logic    char_from_mem;
    status_t status;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic range_err;
    logic full;
    logic at_target;
    logic go_left;
  } sts_t;

endpackage

// File: rtl/gbts_in_if.sv
// request channel: valid/ready plus request payload
// depends on gbts_pkg for field widths
`timescale 1ns / 1ps

interface gbts_in_if;
  logic                         valid;
  logic                         ready;
  logic [gbts_pkg::REQ_W-1:0]   req_type;
  logic [gbts_pkg::POS_W-1:0]   position;
  logic [gbts_pkg::CHAR_W-1:0]  char_in;

  modport source (output valid, req_type, position, char_in, input ready);
  modport sink   (input valid, req_type, position, char_in, output ready);
endinterface

// File: rtl/gbts_out_if.sv
// result channel: valid/ready plus result payload
// depends on gbts_pkg for field widths
`timescale 1ns / 1ps

interface gbts_out_if;
  logic                         valid;
  logic                         ready;
  logic [gbts_pkg::CHAR_W-1:0]  char_out;
  logic [gbts_pkg::CNT_W-1:0]   text_count;
  logic [gbts_pkg::ST_W-1:0]    status;

  modport source (output valid, char_out, text_count, status, input ready);
  modport sink   (input valid, char_out, text_count, status, output ready);
endinterface

// File: rtl/gbts_ctrl.sv
// gap buffer controller: request sequencing and gap move stepping
// depends on gbts_pkg (state_t, cmd_t, sts_t)
`timescale 1ns / 1ps

module gbts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  gbts_pkg::sts_t sts,
  output gbts_pkg::cmd_t cmd
);

  gbts_pkg::state_t  state_r, state_nxt;
  gbts_pkg::status_t st_r, st_nxt;
  logic              cfm_r, cfm_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cfm_nxt   = cfm_r;
    case (state_r)
      gbts_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = gbts_pkg::S_CHECK;
          st_nxt    = gbts_pkg::ST_OK;
          cfm_nxt   = 1'b0;
        end
      end
      gbts_pkg::S_CHECK: begin
        case (sts.req)
          gbts_pkg::REQ_INSERT: begin
            if (sts.range_err) begin
              st_nxt    = gbts_pkg::ST_RANGE;
              state_nxt = gbts_pkg::S_RESP;
            end else if (sts.full) begin
              st_nxt    = gbts_pkg::ST_FULL;
              state_nxt = gbts_pkg::S_RESP;
            end else begin
              state_nxt = gbts_pkg::S_MOVE;
            end
          end
          gbts_pkg::REQ_DELETE: begin
            if (sts.range_err) begin
              st_nxt    = gbts_pkg::ST_RANGE;
              state_nxt = gbts_pkg::S_RESP;
            end else begin
              state_nxt = gbts_pkg::S_MOVE;
            end
          end
          gbts_pkg::REQ_READ: begin
            if (sts.range_err) begin
              st_nxt = gbts_pkg::ST_RANGE;
            end else begin
              cfm_nxt = 1'b1;
            end
            state_nxt = gbts_pkg::S_RESP;
          end
          default: state_nxt = gbts_pkg::S_RESP;
        endcase
      end
      gbts_pkg::S_MOVE: begin
        if (sts.at_target) begin
          state_nxt = gbts_pkg::S_RESP;
          if (sts.req == gbts_pkg::REQ_DELETE) begin
            cfm_nxt = 1'b1;
          end
        end else begin
          state_nxt = gbts_pkg::S_SHIFT;
        end
      end
      gbts_pkg::S_SHIFT: state_nxt = gbts_pkg::S_MOVE;
      gbts_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = gbts_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbts_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = gbts_pkg::RD_NONE;
    cmd.status = st_r;
    in_ready   = 1'b0;
    case (state_r)
      gbts_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      gbts_pkg::S_CHECK: begin
        if (sts.req == gbts_pkg::REQ_READ && !sts.range_err) begin
          cmd.rd_sel = gbts_pkg::RD_POS;
        end
      end
      gbts_pkg::S_MOVE: begin
        if (sts.at_target) begin
          if (sts.req == gbts_pkg::REQ_DELETE) begin
            cmd.rd_sel  = gbts_pkg::RD_LEFT;
            cmd.del_pop = 1'b1;
          end else begin
            cmd.ins_write = 1'b1;
          end
        end else begin
          cmd.rd_sel = sts.go_left ? gbts_pkg::RD_LEFT : gbts_pkg::RD_RIGHT;
        end
      end
      gbts_pkg::S_SHIFT: begin
        cmd.shift_left  = sts.go_left;
        cmd.shift_right = !sts.go_left;
      end
      gbts_pkg::S_RESP: begin
        cmd.load_result   = out_free;
        cmd.char_from_mem = cfm_r;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_result || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbts_pkg::S_IDLE;
      st_r        <= gbts_pkg::ST_OK;
      cfm_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      cfm_r       <= cfm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/gbts_dp.sv
// gap buffer datapath: character store, gap pointers, result register
// depends on gbts_pkg (cmd_t, sts_t, field widths)
`timescale 1ns / 1ps

module gbts_dp #(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gbts_pkg::REQ_W-1:0]  in_req_type,
  input  logic [gbts_pkg::POS_W-1:0]  in_position,
  input  logic [gbts_pkg::CHAR_W-1:0] in_char_in,
  input  gbts_pkg::cmd_t              cmd,
  output gbts_pkg::sts_t              sts,
  output logic [gbts_pkg::CHAR_W-1:0] out_char_out,
  output logic [gbts_pkg::CNT_W-1:0]  out_text_count,
  output logic [gbts_pkg::ST_W-1:0]   out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = ((CW > gbts_pkg::POS_W) ? CW : gbts_pkg::POS_W) + 1;

  logic [gbts_pkg::CHAR_W-1:0] mem [CAPACITY];

  // gap is half-open [gs_r, ge_r)
  logic [CW-1:0]               gs_r, gs_nxt;
  logic [CW-1:0]               ge_r, ge_nxt;
  gbts_pkg::req_t              req_r;
  logic [gbts_pkg::POS_W-1:0]  pos_r;
  logic [gbts_pkg::CHAR_W-1:0] char_r;
  logic [gbts_pkg::CHAR_W-1:0] rdata_r;
  logic [gbts_pkg::CHAR_W-1:0] char_out_r;
  logic [gbts_pkg::CNT_W-1:0]  count_r;
  logic [gbts_pkg::ST_W-1:0]   status_r;

  logic [CW-1:0]               total;
  logic [TW-1:0]               pos_ext, total_ext, gs_ext, target, pos_idx;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [gbts_pkg::CHAR_W-1:0] wr_data;

  assign total     = CW'(CAPACITY) - ge_r + gs_r;
  assign pos_ext   = TW'(pos_r);
  assign total_ext = TW'(total);
  assign gs_ext    = TW'(gs_r);
  assign target    = (req_r == gbts_pkg::REQ_DELETE) ? pos_ext + TW'(1) : pos_ext;
  // text past the gap sits shifted by the gap length
  assign pos_idx   = (pos_ext < gs_ext) ? pos_ext : pos_ext + TW'(ge_r - gs_r);

  always_comb begin
    sts.req       = req_r;
    sts.range_err = (req_r == gbts_pkg::REQ_INSERT) ? (pos_ext > total_ext)
                                                    : (pos_ext >= total_ext);
    sts.full      = (total == CW'(CAPACITY));
    sts.at_target = (target == gs_ext);
    sts.go_left   = (target < gs_ext);
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd.rd_sel)
      gbts_pkg::RD_LEFT:  rd_addr = AW'(gs_r - CW'(1));
      gbts_pkg::RD_RIGHT: rd_addr = AW'(ge_r);
      gbts_pkg::RD_POS:   rd_addr = AW'(pos_idx);
      default:            rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = cmd.shift_left || cmd.shift_right || cmd.ins_write;
    wr_addr = AW'(gs_r);
    wr_data = rdata_r;
    gs_nxt  = gs_r;
    ge_nxt  = ge_r;
    if (cmd.shift_left) begin
      wr_addr = AW'(ge_r - CW'(1));
      gs_nxt  = gs_r - CW'(1);
      ge_nxt  = ge_r - CW'(1);
    end else if (cmd.shift_right) begin
      gs_nxt = gs_r + CW'(1);
      ge_nxt = ge_r + CW'(1);
    end else if (cmd.ins_write) begin
      wr_data = char_r;
      gs_nxt  = gs_r + CW'(1);
    end else if (cmd.del_pop) begin
      gs_nxt = gs_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r <= '0;
      ge_r <= CW'(CAPACITY);
    end else begin
      gs_r <= gs_nxt;
      ge_r <= ge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= gbts_pkg::req_t'(in_req_type);
      pos_r  <= in_position;
      char_r <= in_char_in;
    end
    if (cmd.load_result) begin
      char_out_r <= cmd.char_from_mem ? rdata_r : '0;
      count_r    <= gbts_pkg::CNT_W'(total);
      status_r   <= cmd.status;
    end
  end

  assign out_char_out   = char_out_r;
  assign out_text_count = count_r;
  assign out_status     = status_r;

endmodule

// File: rtl/gap_buffer_text_store_core.sv
// Gap buffer text store, top level.
// Requests come in on in_ch (valid/ready): req_type insert/delete/read,
// position and char_in. Each request gives exactly one result beat on out_ch:
// char_out (byte read or deleted, else zero), text_count after the request
// and status (ok, full, position out of range).
// Requests are taken one at a time. in_ch.ready is high while the block is
// idle, also while a finished result still waits in the output register.
// Steps from the accepting edge until out_ch.valid is high:
//   read, refused request or unused type: CHECK, then RESP loads the result
//   insert or delete: CHECK, then a MOVE and SHIFT pair per character the
//   gap crosses (to the position for insert, to position+1 for delete),
//   a last MOVE that writes or pops the character, then RESP loads the result
// Each crossed character costs one store read (MOVE) and one write (SHIFT), so
// the gap move loop dominates; a new request is taken only back in S_IDLE.
// Synchronous reset empties the text (gap spans the whole store) and drops
// any pending result; the store contents are not cleared.
// When the receiver holds out_ch.ready low the result stays put and the block
// waits before loading the next result; it can still accept one request.
// depends on gbts_pkg, gbts_in_if, gbts_out_if, gbts_ctrl, gbts_dp
`timescale 1ns / 1ps

module gap_buffer_text_store_core #(
  parameter int CAPACITY = 1024
) (
  input logic         clk,
  input logic         rst_n,
  gbts_in_if.sink     in_ch,
  gbts_out_if.source  out_ch
);

  gbts_pkg::cmd_t cmd;
  gbts_pkg::sts_t sts;

  gbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbts_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_ch.req_type),
    .in_position    (in_ch.position),
    .in_char_in     (in_ch.char_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_char_out   (out_ch.char_out),
    .out_text_count (out_ch.text_count),
    .out_status     (out_ch.status)
  );

endmodule

// File: rtl/gbts_checker.sv
// port-level checks for the gap buffer text store, bound to the top level
// depends on gbts_pkg and gap_buffer_text_store_core
`timescale 1ns / 1ps

module gbts_checker #(
  parameter int CAPACITY = 1024
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gbts_pkg::CHAR_W-1:0] out_char_out,
  input logic [gbts_pkg::CNT_W-1:0]  out_text_count,
  input logic [gbts_pkg::ST_W-1:0]   out_status
);

  // a result beat waits for the receiver
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result pending after reset");

  // refused requests carry no character
  a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gbts_pkg::ST_OK |-> out_char_out == '0)
    else $error("character on refused request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == gbts_pkg::ST_FULL
      |-> out_text_count == gbts_pkg::CNT_W'(CAPACITY))
    else $error("full status with text not at capacity");

endmodule

bind gap_buffer_text_store_core gbts_checker #(
  .CAPACITY (CAPACITY)
) u_gbts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_char_out   (out_ch.char_out),
  .out_text_count (out_ch.text_count),
  .out_status     (out_ch.status)
);
